// ----- rtl/core/cltl_pkg.sv -----
// Shared types and constants for the C-like text lexer.
package cltl_pkg;

  // Field widths.
  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int KIND_BITS   = 5;

  // Output queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  // Token kind codes.
  localparam logic [KIND_BITS-1:0] KIND_END     = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_STRING  = 5'd25;
  localparam logic [KIND_BITS-1:0] KIND_SPACE   = 5'd26;
  localparam logic [KIND_BITS-1:0] KIND_BREAK   = 5'd27;
  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd28;
  localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd29;
  localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 5'd30;

  // One reported token.
  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] length;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic                   last;
  } tok_t;

  // Up to two tokens produced by one byte, in order.
  typedef struct packed {
    logic a_valid;
    tok_t a;
    logic b_valid;
    tok_t b;
  } push_t;

endpackage

// ----- rtl/core/c_like_text_lexer.sv -----
// Top level of the C-like text lexer: scanner plus result queue.
//
// Usage: text bytes enter on char_code with in_valid; a transaction completes
// when in_valid is high and in_stall is low. Byte 0 ends the text, yields the
// end token and restarts all counters for the next text. Tokens leave on the
// token_kind .. last_of_run ports with out_valid; the receiver holds out_stall
// high to hold a token, which then stays unchanged. last_of_run marks the last
// token caused by one byte; a byte causes zero, one or two tokens.
// keep_separators is written through cfg_valid/cfg_ready (ready is always
// high); the user must write it only while the block is idle, which the
// block itself does not enforce. It selects whether spacing and line-break
// tokens are reported. A byte's tokens are registered into the queue and
// offered in order. Throughput: one byte per cycle while in_stall is low;
// output is one token per cycle from a four-entry queue while out_stall is
// low, and in_stall rises while that queue holds more than two tokens.
// Reset clears the scanner counters, the queue and keep_separators.
module c_like_text_lexer import cltl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   keep_separators,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             char_code,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_BITS-1:0]   token_kind,
  output logic [OFFSET_BITS-1:0] text_start,
  output logic [OFFSET_BITS-1:0] text_length,
  output logic [LINE_BITS-1:0]   line_number,
  output logic [COLUMN_BITS-1:0] column_number,
  output logic                   last_of_run
);

  push_t push;
  tok_t  head;
  logic  full2;
  logic  accept;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign in_stall  = full2;
  assign accept    = in_valid && !full2;

  cltl_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_data  (keep_separators),
    .accept    (accept),
    .char_code (char_code),
    .push      (push)
  );

  cltl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (!out_stall),
    .full2     (full2),
    .not_empty (out_valid),
    .head      (head)
  );

  // Result fields.
  assign token_kind    = head.kind;
  assign text_start    = head.start;
  assign text_length   = head.length;
  assign line_number   = head.line;
  assign column_number = head.column;
  assign last_of_run   = head.last;

endmodule

// ----- rtl/core/cltl_scan.sv -----
// Scanner state and per-byte token decision for the C-like text lexer.
module cltl_scan import cltl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       accept,
  input  logic [7:0] char_code,
  output push_t      push
);

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_SPACE  = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_NUMBER = 6'b001000,
    MODE_STRING = 6'b010000,
    MODE_BREAK  = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_NUL       = 8'h00;

  localparam logic [OFFSET_BITS-1:0] POS_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
  localparam logic [OFFSET_BITS-1:0] LEN_ONE  = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Punctuation code, 0 when the byte is not punctuation.
  function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    case (c)
      8'h28:   k = 5'd1;
      8'h29:   k = 5'd2;
      8'h7B:   k = 5'd3;
      8'h7D:   k = 5'd4;
      8'h3C:   k = 5'd5;
      8'h3E:   k = 5'd6;
      8'h5B:   k = 5'd7;
      8'h5D:   k = 5'd8;
      8'h3D:   k = 5'd9;
      8'h2F:   k = 5'd10;
      8'h3F:   k = 5'd11;
      8'h21:   k = 5'd12;
      8'h2D:   k = 5'd13;
      8'h23:   k = 5'd14;
      8'h2C:   k = 5'd15;
      8'h2A:   k = 5'd16;
      8'h3B:   k = 5'd17;
      8'h3A:   k = 5'd18;
      8'h2B:   k = 5'd19;
      8'h26:   k = 5'd20;
      8'h7E:   k = 5'd21;
      8'h2E:   k = 5'd22;
      8'h7C:   k = 5'd23;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // Scanner registers.
  mode_t                  mode, mode_next;
  logic                   in_escape, in_escape_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [OFFSET_BITS-1:0] token_begin, token_begin_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [COLUMN_BITS-1:0] column_count, column_count_next;
  logic [LINE_BITS-1:0]   token_line, token_line_next;
  logic [COLUMN_BITS-1:0] token_column, token_column_next;
  logic                   prev_cr, prev_cr_next;
  logic                   keep_separators;

  logic                   ea_valid, eb_valid;
  tok_t                   ea, eb;
  logic                   consumed, handled;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [KIND_BITS-1:0]   pk;

  // Saturating increments of the counters.
  assign pos_inc  = (byte_position == POS_MAX) ? byte_position : byte_position + LEN_ONE;
  assign col_inc  = (column_count == COL_MAX) ? column_count : column_count + COL_ONE;
  assign line_inc = (line_count == LINE_MAX) ? line_count : line_count + LINE_ONE;
  assign pk       = punct_kind(char_code);

  // Per-byte decision: continue, close, or close and start a new token.
  always_comb begin
    mode_next          = mode;
    in_escape_next     = in_escape;
    byte_position_next = byte_position;
    token_begin_next   = token_begin;
    line_count_next    = line_count;
    column_count_next  = column_count;
    token_line_next    = token_line;
    token_column_next  = token_column;
    prev_cr_next       = prev_cr;
    consumed           = 1'b0;
    handled            = 1'b0;

    ea_valid  = 1'b0;
    ea.kind   = KIND_END;
    ea.start  = token_begin;
    ea.length = byte_position - token_begin;
    ea.line   = token_line;
    ea.column = token_column;
    ea.last   = 1'b0;
    eb_valid  = 1'b0;
    eb.kind   = KIND_END;
    eb.start  = byte_position;
    eb.length = '0;
    eb.line   = line_count;
    eb.column = column_count;
    eb.last   = 1'b1;

    case (mode)
      MODE_SPACE:  consumed = is_space(char_code);
      MODE_IDENT:  consumed = is_alpha(char_code) || is_digit(char_code) ||
                              (char_code == CH_UNDER);
      MODE_NUMBER: consumed = is_alpha(char_code) || is_digit(char_code) ||
                              (char_code == CH_DOT);
      MODE_STRING: begin
        if (char_code != CH_NUL) begin
          if (in_escape) begin
            in_escape_next = 1'b0;
            consumed       = 1'b1;
          end else if (char_code == CH_QUOTE) begin
            ea_valid           = 1'b1;
            ea.kind            = KIND_STRING;
            mode_next          = MODE_IDLE;
            byte_position_next = pos_inc;
            column_count_next  = col_inc;
            handled            = 1'b1;
          end else begin
            if (char_code == CH_BACKSLASH) in_escape_next = 1'b1;
            consumed = 1'b1;
          end
        end
      end
      MODE_BREAK: begin
        if ((prev_cr && (char_code == CH_LF)) || (!prev_cr && (char_code == CH_CR))) begin
          byte_position_next = pos_inc;
          column_count_next  = COL_ONE;
          ea_valid           = keep_separators;
          ea.kind            = KIND_BREAK;
          ea.length          = pos_inc - token_begin;
          mode_next          = MODE_IDLE;
          handled            = 1'b1;
        end
      end
      default: ;
    endcase

    if (!handled) begin
      if (consumed) begin
        byte_position_next = pos_inc;
        column_count_next  = col_inc;
      end else begin
        // Close whatever token is open.
        case (mode)
          MODE_SPACE: begin
            ea_valid = keep_separators;
            ea.kind  = KIND_SPACE;
          end
          MODE_BREAK: begin
            ea_valid = keep_separators;
            ea.kind  = KIND_BREAK;
          end
          MODE_IDENT: begin
            ea_valid = 1'b1;
            ea.kind  = KIND_IDENT;
          end
          MODE_NUMBER: begin
            ea_valid = 1'b1;
            ea.kind  = KIND_NUMBER;
          end
          MODE_STRING: begin
            ea_valid = 1'b1;
            ea.kind  = KIND_STRING;
          end
          default: ;
        endcase
        mode_next      = MODE_IDLE;
        in_escape_next = 1'b0;

        // Start a token at this byte.
        token_begin_next   = byte_position;
        token_line_next    = line_count;
        token_column_next  = column_count;
        byte_position_next = pos_inc;
        column_count_next  = col_inc;
        if (char_code == CH_NUL) begin
          eb_valid           = 1'b1;
          eb.kind            = KIND_END;
          mode_next          = MODE_IDLE;
          byte_position_next = '0;
          token_begin_next   = '0;
          line_count_next    = LINE_ONE;
          column_count_next  = COL_ONE;
          token_line_next    = LINE_ONE;
          token_column_next  = COL_ONE;
          prev_cr_next       = 1'b0;
        end else if (pk != KIND_END) begin
          eb_valid  = 1'b1;
          eb.kind   = pk;
          eb.length = LEN_ONE;
        end else if (char_code == CH_QUOTE) begin
          mode_next        = MODE_STRING;
          token_begin_next = pos_inc;
        end else if (is_space(char_code)) begin
          mode_next = MODE_SPACE;
        end else if (is_break(char_code)) begin
          mode_next         = MODE_BREAK;
          line_count_next   = line_inc;
          column_count_next = COL_ONE;
          prev_cr_next      = (char_code == CH_CR);
        end else if (is_alpha(char_code) || (char_code == CH_UNDER)) begin
          mode_next = MODE_IDENT;
        end else if (is_digit(char_code)) begin
          mode_next = MODE_NUMBER;
        end else begin
          eb_valid  = 1'b1;
          eb.kind   = KIND_UNKNOWN;
          eb.length = LEN_ONE;
        end
      end
    end

    ea.last = !eb_valid;
  end

  assign push.a_valid = accept && ea_valid;
  assign push.a       = ea;
  assign push.b_valid = accept && eb_valid;
  assign push.b       = eb;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_separators <= 1'b0;
    end else if (cfg_write) begin
      keep_separators <= cfg_data;
    end
  end

  // Scanner state advances on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      in_escape     <= 1'b0;
      byte_position <= '0;
      token_begin   <= '0;
      line_count    <= LINE_ONE;
      column_count  <= COL_ONE;
      token_line    <= LINE_ONE;
      token_column  <= COL_ONE;
      prev_cr       <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      in_escape     <= in_escape_next;
      byte_position <= byte_position_next;
      token_begin   <= token_begin_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      token_line    <= token_line_next;
      token_column  <= token_column_next;
      prev_cr       <= prev_cr_next;
    end
  end

endmodule

// ----- rtl/core/cltl_outq.sv -----
// Result queue: takes up to two tokens per cycle and delivers one per cycle while popped.
module cltl_outq import cltl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output logic  full2,
  output logic  not_empty,
  output tok_t  head
);

  tok_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic [QCNT_BITS-1:0] push_n;
  logic [QPTR_BITS-1:0] wr_ptr_1;
  logic                 do_pop;

  assign wr_ptr_1  = wr_ptr + 1'b1;
  assign push_n    = QCNT_BITS'(push.a_valid) + QCNT_BITS'(push.b_valid);
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];
  // Room for two more tokens is needed before another byte is taken.
  assign full2     = (count > QCNT_BITS'(QUEUE_DEPTH - 2));

  // Token storage, written in order with the first valid token at wr_ptr.
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      entries[wr_ptr] <= push.a;
      if (push.b_valid) entries[wr_ptr_1] <= push.b;
    end else if (push.b_valid) begin
      entries[wr_ptr] <= push.b;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QPTR_BITS-1:0];
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + push_n - QCNT_BITS'(do_pop);
    end
  end

endmodule
